// ===== hw/rtl/dmxdec_pkg.sv =====
// ----------------------------------------------------------------------------
// dmxdec_pkg
// Shared constants and types for the downmix / boxcar / decimate block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmxdec_pkg;

    // default filter shape
    localparam int TAPS_DEF  = 5;
    localparam int DECIM_DEF = 3;

    // sample and accumulator widths
    localparam int SAMPLE_W = 16;   // Q1.15 PCM
    localparam int MONO_W   = 17;   // Q1.16 mono (sum of two channels)
    localparam int ACC_W    = 22;   // signed sum of up to nine mono samples
    localparam int MAG_W    = 21;   // magnitude of that sum plus rounding half

    // reciprocal shift: exact floor division of MAG_W-bit values by d < 32
    localparam int DIV_S = MAG_W + 5;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CH_CNT_W   = 2;
    localparam logic [CH_CNT_W-1:0] CH_CNT_RST = 2'd1;

    // register index codes
    localparam logic [CFG_ADDR_W-3:0] REG_NUM_CHANS = 1'b0;

    // which average the divider applies
    typedef enum logic [1:0] {
        DIV_RAW,    // raw sample 0 of a short stream
        DIV_EDGE,   // start-edge average over the taps that exist
        DIV_FULL    // full centred average
    } t_div_sel;

    // item handed from the window stage to the divider
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        t_div_sel                sel;
    } t_sum_item;

endpackage

`default_nettype wire

// ===== hw/rtl/dmxdec_window.sv =====
// ----------------------------------------------------------------------------
// dmxdec_window
// Downmix to mono, sample window, frame counter and decimation phase.
// Selects the sum for the result an item causes and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmxdec_window #(
    parameter int TAPS       = dmxdec_pkg::TAPS_DEF,
    parameter int DECIMATION = dmxdec_pkg::DECIM_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [dmxdec_pkg::SAMPLE_W-1:0] i_ch0_sample,
    input  wire logic signed [dmxdec_pkg::SAMPLE_W-1:0] i_ch1_sample,
    input  wire logic                                   i_stream_last,
    input  wire logic        [dmxdec_pkg::CH_CNT_W-1:0] i_num_chans,
    output logic                                        o_sum_valid,
    output dmxdec_pkg::t_sum_item                       o_sum_item,
    input  wire logic                                   i_sum_ready
);
    import dmxdec_pkg::*;

    localparam int REACH = TAPS / 2;
    localparam int SPAN  = 2 * REACH + 1;
    localparam int FC_W  = $clog2(SPAN + 1);
    localparam int PH_W  = $clog2(DECIMATION);

    // stream state
    logic signed [MONO_W-1:0] r_win [SPAN-1];
    logic        [FC_W-1:0]   r_frame_count;
    logic        [PH_W-1:0]   r_phase;
    logic signed [MONO_W-1:0] r_first;

    // registered sum stage
    logic      r_sum_valid;
    t_sum_item r_sum_item;

    logic signed [MONO_W-1:0] mono;
    logic signed [MONO_W-1:0] nwin [SPAN];
    logic signed [MONO_W-1:0] sample0;
    logic signed [ACC_W-1:0]  sum_edge;
    logic signed [ACC_W-1:0]  sum_full;
    logic        [FC_W-1:0]   pre;
    logic        [PH_W-1:0]   n_phase;
    logic        [FC_W-1:0]   n_frame_count;
    logic                     centred;
    logic                     emit;
    t_div_sel                 sel;
    logic                     accept;

    assign o_in_ready = !r_sum_valid || i_sum_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign pre        = r_frame_count;
    assign centred    = pre >= FC_W'(REACH);

    // mono in Q1.16: channel sum, or the single channel doubled
    always_comb begin
        if (i_num_chans[1]) begin
            mono = MONO_W'(i_ch0_sample) + MONO_W'(i_ch1_sample);
        end else begin
            mono = {i_ch0_sample, 1'b0};
        end
    end

    // window after this item, newest first
    always_comb begin
        nwin[0] = mono;
        for (int k = 1; k < SPAN; k++) begin
            nwin[k] = r_win[k-1];
        end
    end

    assign sample0 = (pre == '0) ? mono : r_first;

    // start-edge sum: stream samples 0..REACH; full sum over the window
    always_comb begin
        sum_edge = '0;
        for (int j = 0; j <= REACH; j++) begin
            sum_edge = sum_edge + ACC_W'(nwin[TAPS-1-j]);
        end
        sum_full = '0;
        for (int k = 0; k < SPAN; k++) begin
            sum_full = sum_full + ACC_W'(nwin[k]);
        end
    end

    // next centre phase; restarts at the first centred frame
    always_comb begin
        if (pre == FC_W'(REACH)) begin
            n_phase = '0;
        end else if (r_phase == PH_W'(DECIMATION - 1)) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + 1'b1;
        end
        n_frame_count = (pre == FC_W'(SPAN)) ? FC_W'(SPAN) : pre + 1'b1;
    end

    // result decision
    always_comb begin
        emit = 1'b0;
        sel  = DIV_FULL;
        priority if (pre < FC_W'(TAPS - 1)) begin
            emit = i_stream_last && (pre >= FC_W'(DECIMATION - 1));
            sel  = DIV_RAW;
        end else if (pre == FC_W'(TAPS - 1)) begin
            emit = 1'b1;
            sel  = DIV_EDGE;
        end else begin
            emit = centred && (n_phase == '0);
            sel  = DIV_FULL;
        end
    end

    // stream state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SPAN - 1; k++) begin
                r_win[k] <= '0;
            end
            r_frame_count <= '0;
            r_phase       <= '0;
        end else if (accept) begin
            if (i_stream_last) begin
                for (int k = 0; k < SPAN - 1; k++) begin
                    r_win[k] <= '0;
                end
                r_frame_count <= '0;
                r_phase       <= '0;
            end else begin
                for (int k = 0; k < SPAN - 1; k++) begin
                    r_win[k] <= nwin[k];
                end
                r_frame_count <= n_frame_count;
                if (centred) begin
                    r_phase <= n_phase;
                end
            end
        end
    end

    // first sample of the stream, for short streams
    always_ff @(posedge i_clk) begin
        if (accept && (pre == '0)) begin
            r_first <= mono;
        end
    end

    // sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_sum_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_sum_item.sel <= sel;
            unique case (sel)
                DIV_RAW:  r_sum_item.acc <= ACC_W'(sample0);
                DIV_EDGE: r_sum_item.acc <= sum_edge;
                default:  r_sum_item.acc <= sum_full;
            endcase
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum_item  = r_sum_item;

endmodule

`default_nettype wire

// ===== hw/rtl/dmxdec_divide.sv =====
// ----------------------------------------------------------------------------
// dmxdec_divide
// Rounded division of the tap sum by twice the tap count, Q1.16 to Q1.15,
// by reciprocal multiplication. Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmxdec_divide #(
    parameter int TAPS = dmxdec_pkg::TAPS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_sum_valid,
    input  dmxdec_pkg::t_sum_item                       i_sum_item,
    output logic                                        o_sum_ready,
    output logic                                        o_out_valid,
    output logic signed [dmxdec_pkg::SAMPLE_W-1:0]      o_out_sample,
    input  wire logic                                   i_out_ready
);
    import dmxdec_pkg::*;

    localparam int REACH = TAPS / 2;
    localparam int SPAN  = 2 * REACH + 1;
    localparam int PROD_W = MAG_W + DIV_S;
    localparam longint unsigned SCALE = 64'd1 << DIV_S;

    // divisors 2, 2*(REACH+1), 2*SPAN; reciprocals rounded up
    localparam logic [DIV_S-1:0] M_RAW  = DIV_S'((SCALE + 64'd1) / 64'd2);
    localparam logic [DIV_S-1:0] M_EDGE =
        DIV_S'((SCALE + 64'(2 * (REACH + 1)) - 64'd1) / 64'(2 * (REACH + 1)));
    localparam logic [DIV_S-1:0] M_FULL =
        DIV_S'((SCALE + 64'(2 * SPAN) - 64'd1) / 64'(2 * SPAN));

    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic                 neg;
    logic [MAG_W-1:0]     mag_abs;
    logic [MAG_W-1:0]     half;
    logic [MAG_W-1:0]     mag_rnd;
    logic [DIV_S-1:0]     recip;
    logic [PROD_W-1:0]    prod;
    logic [SAMPLE_W:0]    quo;
    logic [SAMPLE_W:0]    res;

    assign o_sum_ready = !r_out_valid || i_out_ready;

    // pick reciprocal and rounding half of the divisor
    always_comb begin
        unique case (i_sum_item.sel)
            DIV_RAW: begin
                recip = M_RAW;
                half  = MAG_W'(1);
            end
            DIV_EDGE: begin
                recip = M_EDGE;
                half  = MAG_W'(REACH + 1);
            end
            default: begin
                recip = M_FULL;
                half  = MAG_W'(SPAN);
            end
        endcase
    end

    // sign-magnitude rounding, ties away from zero
    always_comb begin
        neg     = i_sum_item.acc[ACC_W-1];
        mag_abs = neg ? MAG_W'(-i_sum_item.acc) : MAG_W'(i_sum_item.acc);
        mag_rnd = mag_abs + half;
        prod    = PROD_W'(mag_rnd) * PROD_W'(recip);
        quo     = prod[DIV_S +: SAMPLE_W+1];
        res     = neg ? -quo : quo;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_sum_ready) begin
            r_out_valid <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sum_ready && i_sum_valid) begin
            r_out_sample <= res[SAMPLE_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

`default_nettype wire

// ===== hw/rtl/downmix_boxcar_decimate_by_three.sv =====
// ----------------------------------------------------------------------------
// downmix_boxcar_decimate_by_three
// A result is registered in the window sum stage, then the output register.
// One item per cycle unless stalled; window update is one register step.
// Reset (synchronous, active low): window, frame count, phase and pipeline
// valids cleared; the channel mode register returns to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module downmix_boxcar_decimate_by_three #(
    parameter int TAPS       = dmxdec_pkg::TAPS_DEF,
    parameter int DECIMATION = dmxdec_pkg::DECIM_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [dmxdec_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [dmxdec_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [dmxdec_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                        pready,
    // input items
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [dmxdec_pkg::SAMPLE_W-1:0] i_ch0_sample,
    input  wire logic signed [dmxdec_pkg::SAMPLE_W-1:0] i_ch1_sample,
    input  wire logic                                   i_stream_last,
    // result items
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [dmxdec_pkg::SAMPLE_W-1:0]      o_out_sample
);
    import dmxdec_pkg::*;

    logic [CH_CNT_W-1:0]     r_num_chans;
    logic                    reg_hit;
    logic                    sum_valid;
    logic                    sum_ready;
    t_sum_item               sum_item;

    // register file: channel mode only
    assign pready  = 1'b1;
    assign reg_hit = paddr[CFG_ADDR_W-1:2] == REG_NUM_CHANS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_chans <= CH_CNT_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_num_chans <= pwdata[CH_CNT_W-1:0];
        end
    end

    assign prdata = reg_hit ? CFG_DATA_W'(r_num_chans) : '0;

    // window and sum selection
    dmxdec_window #(
        .TAPS       (TAPS),
        .DECIMATION (DECIMATION)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_ch0_sample    (i_ch0_sample),
        .i_ch1_sample    (i_ch1_sample),
        .i_stream_last   (i_stream_last),
        .i_num_chans     (r_num_chans),
        .o_sum_valid     (sum_valid),
        .o_sum_item      (sum_item),
        .i_sum_ready     (sum_ready)
    );

    // rounding divider and output register
    dmxdec_divide #(
        .TAPS (TAPS)
    ) u_divide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sum_valid  (sum_valid),
        .i_sum_item   (sum_item),
        .o_sum_ready  (sum_ready),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire
